[rtl/core/pt32_pkg.sv]
// Shared types and constants for the 32-bit prime test block.
// Command and status groups between controller and datapath; base table.
// No dependencies.
package pt32_pkg;

  localparam logic [1:0]  BASE_IDX_LAST = 2'd2;
  localparam logic [31:0] LAST_BASE     = 32'd61;

  // Witness bases, in the order the rounds run.
  function automatic logic [5:0] base_of(logic [1:0] idx);
    logic [5:0] b;
    case (idx)
      2'd0:    b = 6'd2;
      2'd1:    b = 6'd7;
      default: b = 6'd61;
    endcase
    return b;
  endfunction

  typedef struct packed {
    logic load;        // capture candidate, clear residues
    logic res_step;    // one bit of the mod-3 / mod-5 scan
    logic split_init;  // d = n-1, s = 0, first base
    logic split_step;  // d >>= 1, s++
    logic round_init;  // load exponent scan, set squaring count to 1
    logic next_base;
    logic e_step;      // consume one exponent bit
    logic mul_sq;      // acc = acc*acc mod n
    logic mul_base;    // acc = acc*base mod n
    logic sq_inc;
  } pt32_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic n_lt2;
    logic n_small_prime;
    logic n_div235;
    logic n_le61;
    logic d_odd;
    logic base_last;
    logic e_bit;
    logic e_last;
    logic started;
    logic mul_done;
    logic acc_one;
    logic acc_m1;
    logic r_done;
  } pt32_stat_t;

endpackage

[rtl/core/pt32_mulmod.sv]
// Shift-and-add modular multiplier: (a * b) mod n, one bit of b per cycle.
// The registered done strobe comes with the final result on res_o. No package dependencies.
// Operands must be below n; n must stay stable while a request runs.
module pt32_mulmod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] n_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  logic [31:0] a_q, b_q, r_q, r_d;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [33:0] t, n1, n2, tr;

  // r < n and a < n keep 2r + a below 3n, so at most two subtracts of n.
  always_comb begin
    t  = {1'b0, r_q, 1'b0} + (b_q[31] ? {2'b00, a_q} : 34'd0);
    n1 = {2'b00, n_i};
    n2 = {1'b0, n_i, 1'b0};
    if (t >= n2) begin
      tr = t - n2;
    end else if (t >= n1) begin
      tr = t - n1;
    end else begin
      tr = t;
    end
    r_d = tr[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (busy_q) begin
      b_q <= {b_q[30:0], 1'b0};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("mulmod restarted while busy");
  a_rem_below_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (r_q < n_i)) else $error("mulmod remainder not reduced");
`endif

endmodule

[rtl/core/pt32_dp.sv]
// Datapath of the prime test: candidate, residue scan, d/s split,
// exponent scan, round counters and the shared modular multiplier.
// Depends on pt32_pkg and pt32_mulmod.
module pt32_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          candidate_i,
  input  pt32_pkg::pt32_cmd_t  cmd_i,
  output pt32_pkg::pt32_stat_t stat_o
);
  import pt32_pkg::*;

  logic [31:0] n_q, nm1_q, sc_q, d_q, esc_q, acc_q;
  logic [1:0]  r3_q;
  logic [2:0]  r5_q;
  logic [4:0]  cnt_q, ecnt_q, s_q, rcnt_q;
  logic [1:0]  bidx_q;
  logic        started_q;
  logic [31:0] base32;
  logic        mm_start, mm_done;
  logic [31:0] mm_b, mm_res;

  function automatic logic [1:0] mod3_step(logic [1:0] r, logic b);
    logic [2:0] v;
    v = {r, 1'b0} + {2'b00, b};
    if (v >= 3'd3) v = v - 3'd3;
    return v[1:0];
  endfunction

  function automatic logic [2:0] mod5_step(logic [2:0] r, logic b);
    logic [3:0] v;
    v = {r, 1'b0} + {3'b000, b};
    if (v >= 4'd5) v = v - 4'd5;
    return v[2:0];
  endfunction

  assign base32   = {26'd0, base_of(bidx_q)};
  assign mm_start = cmd_i.mul_sq | cmd_i.mul_base;
  assign mm_b     = cmd_i.mul_base ? base32 : acc_q;

  pt32_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (acc_q),
    .b_i     (mm_b),
    .n_i     (n_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  // counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ecnt_q    <= '0;
      s_q       <= '0;
      rcnt_q    <= '0;
      bidx_q    <= '0;
      started_q <= 1'b0;
    end else begin
      if (cmd_i.load)       cnt_q  <= '0;
      if (cmd_i.res_step)   cnt_q  <= cnt_q + 5'd1;
      if (cmd_i.split_init) begin
        s_q    <= '0;
        bidx_q <= '0;
      end
      if (cmd_i.split_step) s_q    <= s_q + 5'd1;
      if (cmd_i.next_base)  bidx_q <= bidx_q + 2'd1;
      if (cmd_i.round_init) begin
        ecnt_q    <= '0;
        rcnt_q    <= 5'd1;
        started_q <= 1'b0;
      end
      if (cmd_i.e_step) begin
        ecnt_q <= ecnt_q + 5'd1;
        if (esc_q[31]) started_q <= 1'b1;
      end
      if (cmd_i.sq_inc)     rcnt_q <= rcnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q  <= candidate_i;
      sc_q <= candidate_i;
      r3_q <= '0;
      r5_q <= '0;
    end
    if (cmd_i.res_step) begin
      r3_q <= mod3_step(r3_q, sc_q[31]);
      r5_q <= mod5_step(r5_q, sc_q[31]);
      sc_q <= {sc_q[30:0], 1'b0};
    end
    if (cmd_i.split_init) begin
      d_q   <= n_q - 32'd1;
      nm1_q <= n_q - 32'd1;
    end
    if (cmd_i.split_step) d_q <= {1'b0, d_q[31:1]};
    if (cmd_i.round_init) esc_q <= d_q;
    if (cmd_i.e_step) begin
      esc_q <= {esc_q[30:0], 1'b0};
      // leading one of d: acc starts at the base instead of squaring ones
      if (!started_q && esc_q[31]) acc_q <= base32;
    end
    if (mm_done) acc_q <= mm_res;
  end

  always_comb begin
    stat_o.scan_last     = (cnt_q == 5'd31);
    stat_o.n_lt2         = (n_q[31:1] == 31'd0);
    stat_o.n_small_prime = (n_q == 32'd2) || (n_q == 32'd3) ||
                           (n_q == 32'd5) || (n_q == 32'd7);
    stat_o.n_div235      = !n_q[0] || (r3_q == 2'd0) || (r5_q == 3'd0);
    stat_o.n_le61        = (n_q <= LAST_BASE);
    stat_o.d_odd         = d_q[0];
    stat_o.base_last     = (bidx_q == BASE_IDX_LAST);
    stat_o.e_bit         = esc_q[31];
    stat_o.e_last        = (ecnt_q == 5'd31);
    stat_o.started       = started_q;
    stat_o.mul_done      = mm_done;
    stat_o.acc_one       = (acc_q == 32'd1);
    stat_o.acc_m1        = (acc_q == nm1_q);
    stat_o.r_done        = (rcnt_q == s_q);
  end

endmodule

[rtl/core/pt32_ctrl.sv]
// Controller of the prime test: sequences residue scan, split of n-1,
// exponentiation and squaring rounds; owns busy and the result register.
// Depends on pt32_pkg.
module pt32_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic                 is_prime_o,
  output pt32_pkg::pt32_cmd_t  cmd_o,
  input  pt32_pkg::pt32_stat_t stat_i
);
  import pt32_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RES     = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_SPLIT   = 4'd3;
  localparam logic [3:0] S_RINIT   = 4'd4;
  localparam logic [3:0] S_EXP_BIT = 4'd5;
  localparam logic [3:0] S_EXP_SQW = 4'd6;
  localparam logic [3:0] S_EXP_MB  = 4'd7;
  localparam logic [3:0] S_EXP_MW  = 4'd8;
  localparam logic [3:0] S_RTEST   = 4'd9;
  localparam logic [3:0] S_RSQ     = 4'd10;
  localparam logic [3:0] S_RSQW    = 4'd11;
  localparam logic [3:0] S_RSQCHK  = 4'd12;
  localparam logic [3:0] S_NBASE   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       done_q, prime_q;
  logic       fin, fin_val;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    fin     = 1'b0;
    fin_val = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RES;
        end
      end
      S_RES: begin
        cmd_o.res_step = 1'b1;
        if (stat_i.scan_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.n_lt2) begin
          fin = 1'b1;
        end else if (stat_i.n_small_prime) begin
          fin     = 1'b1;
          fin_val = 1'b1;
        end else if (stat_i.n_div235) begin
          fin = 1'b1;
        end else begin
          cmd_o.split_init = 1'b1;
          state_d          = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (stat_i.d_odd) begin
          state_d = S_RINIT;
        end else begin
          cmd_o.split_step = 1'b1;
        end
      end
      S_RINIT: begin
        // on the last base, the loop ends (prime) once n is no larger than that base
        if (stat_i.base_last && stat_i.n_le61) begin
          fin     = 1'b1;
          fin_val = 1'b1;
        end else begin
          cmd_o.round_init = 1'b1;
          state_d          = S_EXP_BIT;
        end
      end
      S_EXP_BIT: begin
        if (stat_i.started) begin
          cmd_o.mul_sq = 1'b1;
          state_d      = S_EXP_SQW;
        end else begin
          cmd_o.e_step = 1'b1;
          if (stat_i.e_last) state_d = S_RTEST;
        end
      end
      S_EXP_SQW: begin
        if (stat_i.mul_done) begin
          if (stat_i.e_bit) begin
            state_d = S_EXP_MB;
          end else begin
            cmd_o.e_step = 1'b1;
            state_d      = stat_i.e_last ? S_RTEST : S_EXP_BIT;
          end
        end
      end
      S_EXP_MB: begin
        cmd_o.mul_base = 1'b1;
        state_d        = S_EXP_MW;
      end
      S_EXP_MW: begin
        if (stat_i.mul_done) begin
          cmd_o.e_step = 1'b1;
          state_d      = stat_i.e_last ? S_RTEST : S_EXP_BIT;
        end
      end
      S_RTEST: begin
        state_d = (stat_i.acc_one || stat_i.acc_m1) ? S_NBASE : S_RSQ;
      end
      S_RSQ: begin
        if (stat_i.r_done) begin
          fin = 1'b1;
        end else begin
          cmd_o.mul_sq = 1'b1;
          state_d      = S_RSQW;
        end
      end
      S_RSQW: begin
        if (stat_i.mul_done) begin
          cmd_o.sq_inc = 1'b1;
          state_d      = S_RSQCHK;
        end
      end
      S_RSQCHK: begin
        state_d = stat_i.acc_m1 ? S_NBASE : S_RSQ;
      end
      S_NBASE: begin
        if (stat_i.base_last) begin
          fin     = 1'b1;
          fin_val = 1'b1;
        end else begin
          cmd_o.next_base = 1'b1;
          state_d         = S_RINIT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      prime_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (fin) prime_q <= fin_val;
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

`ifndef SYNTH
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("request accepted but not busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while still busy");
`endif

endmodule

[rtl/core/prime_test_32bit.sv]
// Deterministic 32-bit primality test (strong probable-prime rounds for
// bases 2, 7 and 61 after trial checks by 2, 3 and 5).
//
// Request channel: drive candidate_i and raise start; the request is taken
// at a rising edge where start is high and busy is low. busy stays high
// until the result is produced; start is ignored meanwhile.
// Result channel: done_o is high for exactly one cycle with is_prime_o
// valid in that cycle. The receiver cannot stall; the result is gone after
// that cycle (is_prime_o keeps its value until the next result).
// Values below 2, the small primes and multiples of 2, 3 or 5 finish
// after the residue scan. Otherwise the block splits n-1, then per base
// runs the exponent scan with the multiplies of the exponentiation and
// then the later squarings (one bit-serial multiply-reduce unit, shared
// by all squarings and base multiplies).
// One request is in flight at a time; busy drops in the cycle done_o is
// high, so the next request can be taken right then.
// Reset: asynchronous, active low; returns to idle with no result pending.
// Depends on pt32_pkg, pt32_ctrl, pt32_dp, pt32_mulmod.
module prime_test_32bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] candidate_i,
  output logic        done_o,
  output logic        is_prime_o
);
  import pt32_pkg::*;

  pt32_cmd_t  cmd;
  pt32_stat_t stat;

  pt32_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .done_o     (done_o),
    .is_prime_o (is_prime_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  pt32_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .candidate_i (candidate_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
